// ===== rtl/xml_entity_unescaper_defines.svh =====
// Assertion macros shared by the XML entity unescaper checkers.
`ifndef XML_ENTITY_UNESCAPER_DEFINES_SVH
`define XML_ENTITY_UNESCAPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XEU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/xeu_pkg.sv =====
// Package: constants, entity tables and the command record of the unescaper.
`timescale 1ns / 1ps

package xeu_pkg;

    localparam int NUM_ENT         = 5;
    localparam int HOLD_DEPTH      = 5;
    localparam int HOLD_CNT_W      = $clog2(HOLD_DEPTH + 1);
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] AMP_CHAR = 8'h26;

    // Entity indexes, also the bit positions in the live mask
    localparam logic [2:0] ENT_LT   = 3'd0;
    localparam logic [2:0] ENT_GT   = 3'd1;
    localparam logic [2:0] ENT_AMP  = 3'd2;
    localparam logic [2:0] ENT_APOS = 3'd3;
    localparam logic [2:0] ENT_QUOT = 3'd4;

    // One front-end decision: flush held bytes, then optionally one tail byte
    typedef struct packed {
        logic [HOLD_CNT_W-1:0]        flush_cnt;
        logic [HOLD_DEPTH-1:0][7:0]   held;
        logic                         tail_valid;
        logic [7:0]                   tail_byte;
        logic                         text_end;
    } xeu_cmd_t;

    // Length of the entity text after the ampersand
    function automatic logic [2:0] ent_len(input logic [2:0] e);
        logic [2:0] len;
        unique case (e)
            ENT_LT:   len = 3'd3;
            ENT_GT:   len = 3'd3;
            ENT_AMP:  len = 3'd4;
            ENT_APOS: len = 3'd5;
            ENT_QUOT: len = 3'd5;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    // Character the entity decodes to
    function automatic logic [7:0] ent_decoded(input logic [2:0] e);
        logic [7:0] ch;
        unique case (e)
            ENT_LT:   ch = 8'h3C;
            ENT_GT:   ch = 8'h3E;
            ENT_AMP:  ch = 8'h26;
            ENT_APOS: ch = 8'h27;
            ENT_QUOT: ch = 8'h22;
            default:  ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Byte at position pos of the entity text after the ampersand
    function automatic logic [7:0] ent_tail_byte(input logic [2:0] e, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (e)
            ENT_LT:
                case (pos)
                    3'd0:    ch = 8'h6C;  // l
                    3'd1:    ch = 8'h74;  // t
                    3'd2:    ch = 8'h3B;  // ;
                    default: ch = 8'h00;
                endcase
            ENT_GT:
                case (pos)
                    3'd0:    ch = 8'h67;  // g
                    3'd1:    ch = 8'h74;  // t
                    3'd2:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            ENT_AMP:
                case (pos)
                    3'd0:    ch = 8'h61;  // a
                    3'd1:    ch = 8'h6D;  // m
                    3'd2:    ch = 8'h70;  // p
                    3'd3:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            ENT_APOS:
                case (pos)
                    3'd0:    ch = 8'h61;  // a
                    3'd1:    ch = 8'h70;  // p
                    3'd2:    ch = 8'h6F;  // o
                    3'd3:    ch = 8'h73;  // s
                    3'd4:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            ENT_QUOT:
                case (pos)
                    3'd0:    ch = 8'h71;  // q
                    3'd1:    ch = 8'h75;  // u
                    3'd2:    ch = 8'h6F;  // o
                    3'd3:    ch = 8'h74;  // t
                    3'd4:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/xml_entity_unescaper.sv =====
// Top level of the XML predefined-entity unescaper.
// One raw byte is taken per cycle; the input stalls only when the queue is
// full. A byte that completes, breaks or bypasses an entity turns into a
// command in a QUEUE_DEPTH-entry queue, and the output serializer sends one
// byte per cycle from it while out_stall is low, so a transaction that yields
// k result bytes (1 to 6, k > 1 only when a held prefix is flushed) leaves as
// one run of k bytes; bytes that only extend a held prefix give no result.
// With no output stall and single-byte runs the block sustains one byte per
// cycle, and a result appears the cycle after its input is accepted.
`timescale 1ns / 1ps

module xml_entity_unescaper
    import xeu_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_last
);

    xeu_cmd_t push_cmd;
    xeu_cmd_t head_cmd;
    logic     push;
    logic     full;
    logic     pop;
    logic     head_valid;

    xeu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .string_end (string_end),
        .cmd_valid  (push),
        .cmd        (push_cmd),
        .cmd_full   (full)
    );

    xeu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    xeu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .text_last  (text_last)
    );

endmodule

// ===== rtl/xeu_front.sv =====
// Front end: accepts raw bytes, tracks the entity prefix and issues commands.
`timescale 1ns / 1ps

module xeu_front
    import xeu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    output logic       cmd_valid,
    output xeu_cmd_t   cmd,
    input  logic       cmd_full
);

    logic [HOLD_CNT_W-1:0]      held_count_reg, held_count_next;
    logic [NUM_ENT-1:0]         live_reg, live_next;
    logic [HOLD_DEPTH-1:0][7:0] held_reg;

    logic                  in_fire;
    logic                  start_hold;
    logic [2:0]            pos;
    logic [NUM_ENT-1:0]    new_live;
    logic                  done_vld;
    logic [7:0]            done_char;
    logic                  held_wr_en;
    logic [HOLD_CNT_W-1:0] held_wr_idx;
    logic [7:0]            held_wr_data;

    assign in_stall   = cmd_full;
    assign in_fire    = in_valid && !cmd_full;
    assign start_hold = (in_byte == AMP_CHAR) && !string_end;
    assign pos        = 3'(held_count_reg - HOLD_CNT_W'(1));

    // Compare the byte against every entity still alive at this position
    always_comb
    begin
        new_live  = '0;
        done_vld  = 1'b0;
        done_char = 8'h00;
        if (held_count_reg <= HOLD_CNT_W'(HOLD_DEPTH))
        begin
            for (int e = 0; e < NUM_ENT; e++)
            begin
                if (live_reg[e] && (pos < ent_len(3'(e)))
                    && (ent_tail_byte(3'(e), pos) == in_byte))
                begin
                    new_live[e] = 1'b1;
                    if ((4'(pos) + 4'd1) == 4'(ent_len(3'(e))))
                    begin
                        done_vld  = 1'b1;
                        done_char = ent_decoded(3'(e));
                    end
                end
            end
        end
    end

    always_comb
    begin
        held_count_next = held_count_reg;
        live_next       = live_reg;
        held_wr_en      = 1'b0;
        held_wr_idx     = '0;
        held_wr_data    = AMP_CHAR;
        cmd.flush_cnt   = '0;
        cmd.held        = held_reg;
        cmd.tail_valid  = 1'b0;
        cmd.tail_byte   = in_byte;
        cmd.text_end    = string_end;

        if (held_count_reg == '0)
        begin
            if (start_hold)
            begin
                held_count_next = HOLD_CNT_W'(1);
                live_next       = '1;
                held_wr_en      = 1'b1;
            end
            else
            begin
                cmd.tail_valid = 1'b1;
            end
        end
        else if (done_vld)
        begin
            held_count_next = '0;
            live_next       = '0;
            cmd.tail_valid  = 1'b1;
            cmd.tail_byte   = done_char;
        end
        else if ((new_live != '0) && !string_end
                 && (held_count_reg < HOLD_CNT_W'(HOLD_DEPTH)))
        begin
            // Still a prefix: keep holding
            held_count_next = held_count_reg + HOLD_CNT_W'(1);
            live_next       = new_live;
            held_wr_en      = 1'b1;
            held_wr_idx     = held_count_reg;
            held_wr_data    = in_byte;
        end
        else
        begin
            // Broken prefix: flush literally, then restart or pass the byte
            cmd.flush_cnt = (held_count_reg > HOLD_CNT_W'(HOLD_DEPTH))
                          ? HOLD_CNT_W'(HOLD_DEPTH) : held_count_reg;
            if (start_hold)
            begin
                held_count_next = HOLD_CNT_W'(1);
                live_next       = '1;
                held_wr_en      = 1'b1;
            end
            else
            begin
                held_count_next = '0;
                live_next       = '0;
                cmd.tail_valid  = 1'b1;
            end
        end
    end

    assign cmd_valid = in_fire && ((cmd.flush_cnt != '0) || cmd.tail_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            live_reg       <= '0;
        end
        else if (in_fire)
        begin
            held_count_reg <= held_count_next;
            live_reg       <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && held_wr_en)
        begin
            held_reg[held_wr_idx] <= held_wr_data;
        end
    end

endmodule

// ===== rtl/xeu_queue.sv =====
// Command queue between the front end and the output serializer.
`timescale 1ns / 1ps

module xeu_queue
    import xeu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  xeu_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output xeu_cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xeu_cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/xeu_back.sv =====
// Back end: expands one command into its run of output bytes.
`timescale 1ns / 1ps

module xeu_back
    import xeu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  xeu_cmd_t   head_cmd,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_last
);

    logic [HOLD_CNT_W-1:0] idx_reg, idx_next;
    logic [HOLD_CNT_W-1:0] run_len;
    logic                  is_last;
    logic                  out_fire;

    assign run_len  = head_cmd.flush_cnt + HOLD_CNT_W'(head_cmd.tail_valid);
    assign is_last  = (idx_reg == run_len - HOLD_CNT_W'(1));
    assign out_fire = head_valid && !out_stall;
    assign pop      = out_fire && is_last;

    assign out_valid = head_valid;
    assign out_byte  = (idx_reg < head_cmd.flush_cnt) ? head_cmd.held[idx_reg]
                                                      : head_cmd.tail_byte;
    assign run_last  = is_last;
    assign text_last = is_last && head_cmd.text_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (out_fire)
        begin
            idx_next = is_last ? '0 : idx_reg + HOLD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== rtl/xeu_checker.sv =====
// Port-level checker for the unescaper, bound to the top level.
`timescale 1ns / 1ps
`include "xml_entity_unescaper_defines.svh"

module xeu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       string_end,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       text_last
);

    // Hold a stalled input transaction
    `XEU_ASSERT_NEXT(a_in_hold, clk, rst_n,
        in_valid && in_stall,
        in_valid && $stable(in_byte) && $stable(string_end),
        "stalled input changed")

    // End of text only closes a run
    `XEU_ASSERT_NOW(a_text_last_ends_run, clk, rst_n,
        out_valid && text_last, run_last,
        "text_last without run_last")

    // A run in progress has its next byte ready at once
    `XEU_ASSERT_NEXT(a_run_continues, clk, rst_n,
        out_valid && !out_stall && !run_last, out_valid,
        "run broken before its last byte")

    // Hold a stalled transaction
    `XEU_ASSERT_NEXT(a_out_hold, clk, rst_n,
        out_valid && out_stall,
        out_valid && $stable(out_byte) && $stable(run_last) && $stable(text_last),
        "stalled output changed")

    // A stalled run keeps its place
    `XEU_ASSERT_NEXT(a_out_hold_last, clk, rst_n,
        out_valid && out_stall && !run_last, !run_last,
        "stalled run_last rose")

endmodule

bind xml_entity_unescaper xeu_checker u_xeu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .string_end (string_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .text_last  (text_last)
);
